/* hw/rtl/txrb_pkg.sv */
package txrb_pkg;

	// Store geometry and drain burst length
	localparam int DEPTH = 256;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BURST = 4;
	localparam int CNT_W = (BURST > 1) ? $clog2(BURST) : 1;

	// Request opcodes
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_TX   = 2'd1,
		KIND_NONE = 2'd2
	} kind_t;

	// Push status codes
	typedef enum logic [1:0] {
		ST_STORED   = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	// Classified command handed from front to back
	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_REJECT = 2'd1,
		CMD_DRAIN  = 2'd2
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t  code;
		logic [7:0] data;
	} cmd_t;

	// Back end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_FETCH = 2'd1,
		BK_SEND  = 2'd2
	} bk_state_t;

	// One result item
	typedef struct packed {
		kind_t      kind;
		logic [7:0] tx_byte;
		status_t    push_status;
		logic       now_empty;
		logic       last;
	} res_t;

	// Pointer advance with wrap at DEPTH
	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

/* hw/rtl/txrb_if.sv */
// Request channel: opcode and byte
interface txrb_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] push_byte;

	modport source (output valid, output op, output push_byte, input ready);
	modport sink   (input valid, input op, input push_byte, output ready);
endinterface

// Result channel
interface txrb_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] tx_byte;
	logic [1:0] push_status;
	logic       now_empty;
	logic       last;

	modport source (output valid, output kind, output tx_byte, output push_status,
		output now_empty, output last, input ready);
	modport sink   (input valid, input kind, input tx_byte, input push_status,
		input now_empty, input last, output ready);
endinterface

/* hw/rtl/txrb_front.sv */
module txrb_front (
	input  logic              clk,
	input  logic              arst_n,
	txrb_in_if.sink           in_ch,
	output logic              cmd_valid,
	output txrb_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);

	txrb_pkg::cmd_t q_mem_q [2];
	logic           wr_idx_q;
	logic           rd_idx_q;
	logic [1:0]     cnt_q;
	logic           push_en;
	txrb_pkg::cmd_t cls;

	// Classify the incoming request
	always_comb begin
		cls.data = in_ch.push_byte;
		if (in_ch.op == txrb_pkg::OP_DRAIN) begin
			cls.code = txrb_pkg::CMD_DRAIN;
		end else if (in_ch.push_byte == 8'd0) begin
			cls.code = txrb_pkg::CMD_REJECT;
		end else begin
			cls.code = txrb_pkg::CMD_PUSH;
		end
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push_en     = in_ch.valid && in_ch.ready;
	assign cmd_valid   = (cnt_q != 2'd0);
	assign cmd         = q_mem_q[rd_idx_q];

	// Two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_en) begin
				wr_idx_q <= ~wr_idx_q;
			end
			if (cmd_pop) begin
				rd_idx_q <= ~rd_idx_q;
			end
			if (push_en && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push_en && cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			q_mem_q[wr_idx_q] <= cls;
		end
	end

endmodule

/* hw/rtl/txrb_back.sv */
module txrb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  txrb_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	txrb_out_if.source        out_ch
);

	logic [7:0]                   byte_store [txrb_pkg::DEPTH];
	logic [7:0]                   rd_data_q;
	logic [txrb_pkg::PTR_W-1:0]   wptr_q, wptr_d;
	logic [txrb_pkg::PTR_W-1:0]   rptr_q, rptr_d;
	logic [txrb_pkg::PTR_W-1:0]   wp_adv, rp_adv;
	logic [txrb_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	txrb_pkg::bk_state_t          state_q, state_d;
	txrb_pkg::res_t               res_q, res_d;
	logic                         out_valid_q;
	logic                         out_free;
	logic                         res_load;
	logic                         wr_en;
	logic                         is_empty;

	assign out_free = !out_valid_q || out_ch.ready;
	assign is_empty = (wptr_q == rptr_q);
	assign wp_adv   = txrb_pkg::ptr_adv(wptr_q);
	assign rp_adv   = txrb_pkg::ptr_adv(rptr_q);

	// Sequencer: next state, pointer updates and result build
	always_comb begin
		state_d  = state_q;
		wptr_d   = wptr_q;
		rptr_d   = rptr_q;
		cnt_d    = cnt_q;
		cmd_pop  = 1'b0;
		wr_en    = 1'b0;
		res_load = 1'b0;
		res_d    = '0;
		unique case (state_q)
			txrb_pkg::BK_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					unique case (cmd.code)
						txrb_pkg::CMD_PUSH: begin
							wr_en             = 1'b1;
							wptr_d            = wp_adv;
							res_load          = 1'b1;
							res_d.kind        = txrb_pkg::KIND_PUSH;
							res_d.last        = 1'b1;
							res_d.push_status = txrb_pkg::ST_STORED;
							// full: oldest byte is overwritten
							if (wp_adv == rptr_q) begin
								rptr_d            = rp_adv;
								res_d.push_status = txrb_pkg::ST_DROPPED;
							end
						end
						txrb_pkg::CMD_REJECT: begin
							res_load          = 1'b1;
							res_d.kind        = txrb_pkg::KIND_PUSH;
							res_d.push_status = txrb_pkg::ST_REJECTED;
							res_d.now_empty   = is_empty;
							res_d.last        = 1'b1;
						end
						txrb_pkg::CMD_DRAIN: begin
							if (is_empty) begin
								res_load        = 1'b1;
								res_d.kind      = txrb_pkg::KIND_NONE;
								res_d.now_empty = 1'b1;
								res_d.last      = 1'b1;
							end else begin
								cnt_d   = '0;
								state_d = txrb_pkg::BK_FETCH;
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			txrb_pkg::BK_FETCH: begin
				// store read of the head entry in flight
				state_d = txrb_pkg::BK_SEND;
			end
			txrb_pkg::BK_SEND: begin
				if (out_free) begin
					rptr_d          = rp_adv;
					res_load        = 1'b1;
					res_d.kind      = txrb_pkg::KIND_TX;
					res_d.tx_byte   = rd_data_q;
					res_d.now_empty = (rp_adv == wptr_q);
					res_d.last      = (rp_adv == wptr_q) ||
						(cnt_q == txrb_pkg::CNT_W'(txrb_pkg::BURST - 1));
					if (res_d.last) begin
						state_d = txrb_pkg::BK_IDLE;
					end else begin
						cnt_d = cnt_q + txrb_pkg::CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = txrb_pkg::BK_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= txrb_pkg::BK_IDLE;
			wptr_q      <= '0;
			rptr_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wptr_q  <= wptr_d;
			rptr_q  <= rptr_d;
			cnt_q   <= cnt_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// Byte store: one write port, registered read at the next head
	always_ff @(posedge clk) begin
		if (wr_en) begin
			byte_store[wptr_q] <= cmd.data;
		end
		rd_data_q <= byte_store[rptr_d];
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.kind        = res_q.kind;
	assign out_ch.tx_byte     = res_q.tx_byte;
	assign out_ch.push_status = res_q.push_status;
	assign out_ch.now_empty   = res_q.now_empty;
	assign out_ch.last        = res_q.last;

endmodule

/* hw/rtl/tx_ring_buffer_overwrite_burst.sv */
// Push or rejected push: result registered when the request is taken from the
// command queue; pushes sustain one request per cycle unless results stall.
// Drain: the queue hands it over in idle, the store read runs in fetch and the
// first byte is registered in send; then one byte per cycle unless results stall.
// Reset: pointers zero, queue and result register empty; store contents are kept.
module tx_ring_buffer_overwrite_burst (
	input  logic        clk,
	input  logic        arst_n,
	txrb_in_if.sink     in_ch,
	txrb_out_if.source  out_ch
);

	logic           cmd_valid;
	logic           cmd_pop;
	txrb_pkg::cmd_t cmd;

	// Front: accept and classify
	txrb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back: ring buffer and burst drain
	txrb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_ch    (out_ch)
	);

endmodule

/* hw/rtl/txrb_checker.sv */
module txrb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] tx_byte,
	input logic [1:0] push_status,
	input logic       now_empty,
	input logic       last
);

	// Stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Stalled result keeps its kind, byte and last flag
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(kind) && $stable(tx_byte) && $stable(last))
		else $error("result payload changed while stalled");

	// Push acknowledge is a single-result request
	a_push_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == txrb_pkg::KIND_PUSH |-> last)
		else $error("push acknowledge without last");

	// Nothing to send means the buffer is empty and the request is done
	a_none_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == txrb_pkg::KIND_NONE
		|-> now_empty && last && push_status == txrb_pkg::ST_STORED)
		else $error("empty drain result malformed");

	// A byte that empties the buffer closes the burst
	a_tx_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == txrb_pkg::KIND_TX && now_empty |-> last)
		else $error("burst continues past empty buffer");

endmodule

bind tx_ring_buffer_overwrite_burst txrb_checker u_txrb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.kind        (out_ch.kind),
	.tx_byte     (out_ch.tx_byte),
	.push_status (out_ch.push_status),
	.now_empty   (out_ch.now_empty),
	.last        (out_ch.last)
);
